// ----- sv/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared widths, codes and beat types of the csv field splitter.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int DATA_W    = 8;
  localparam int MAXF_W    = 7;
  localparam int IDX_W     = 6;
  localparam int OFS_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_FIELDS = 64;
  localparam int DEF_LINE_BYTES = 65535;

  localparam logic [DATA_W-1:0] RST_DELIMITER   = 8'd44;
  localparam logic [MAXF_W-1:0] RST_FIELD_LIMIT = 7'd64;

  localparam logic [DATA_W-1:0] QUOTE_CH = 8'h22;
  localparam logic [DATA_W-1:0] SPACE_CH = 8'h20;
  localparam logic [DATA_W-1:0] TAB_CH   = 8'h09;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_LIMIT = 2'd1;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] delimiter;
    logic [MAXF_W-1:0] field_limit;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] field_index;
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] field_length;
    logic             last_field;
    logic             line_overflow;
  } result_t;

endpackage

// ----- sv/cfs_ifs.sv -----
// ----------------------------------------------------------------------------
// cfs channel interfaces
// Valid/ready channels for line bytes, field results and register writes.
// ----------------------------------------------------------------------------
interface cfs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [cfs_pkg::DATA_W-1:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface cfs_out_if;
  logic                      valid;
  logic                      ready;
  logic [cfs_pkg::IDX_W-1:0] field_index;
  logic [cfs_pkg::OFS_W-1:0] start_ofs;
  logic [cfs_pkg::OFS_W-1:0] field_length;
  logic                      last_field;
  logic                      line_overflow;
  modport source (output valid, field_index, start_ofs, field_length, last_field,
                  line_overflow, input ready);
  modport sink   (input valid, field_index, start_ofs, field_length, last_field,
                  line_overflow, output ready);
endinterface

interface cfs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfs_pkg::CFG_IDX_W-1:0] index;
  logic [cfs_pkg::DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/cfs_parser.sv -----
// ----------------------------------------------------------------------------
// cfs_parser
// Per-byte field state machine with the registered field result.
// ----------------------------------------------------------------------------
module cfs_parser #(
  parameter int MAX_FIELDS = cfs_pkg::DEF_MAX_FIELDS,
  parameter int LINE_BYTES = cfs_pkg::DEF_LINE_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  cfs_pkg::item_t   item,
  input  cfs_pkg::cfg_t    cfg,
  input  logic             take,
  output logic             res_valid,
  output cfs_pkg::result_t res
);

  localparam int POS_CAP = (LINE_BYTES < 65535) ? LINE_BYTES : 65535;
  localparam int POS_W   = $clog2(POS_CAP + 1);
  localparam int CAP_MAX = (MAX_FIELDS < 127) ? MAX_FIELDS : 127;
  localparam int FD_W    = $clog2(CAP_MAX + 1);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_CAP);

  typedef enum logic [2:0] {
    PH_EMPTY, PH_START, PH_UNQ, PH_QUOTED, PH_QPEND, PH_DONE
  } phase_t;

  phase_t            phase_r, phase_nxt, eff_phase;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FD_W-1:0]   fields_done_r, fields_done_nxt;
  logic [POS_W-1:0]  cb_r, cb_nxt;
  logic [POS_W-1:0]  te_r, te_nxt;
  logic              text_seen_r, text_seen_nxt, eff_seen;
  logic              ovf_r, ovf_nxt;
  logic              res_valid_r, res_valid_nxt;
  cfs_pkg::result_t  res_r, res_nxt;

  logic [FD_W-1:0]   cap;
  logic [FD_W:0]     fd_inc;
  logic [POS_W-1:0]  pos_inc;
  logic              is_blank;
  logic              is_delim;
  logic              is_quote;
  logic              req;
  logic              force_last;
  logic              emit_ok;
  logic              emit_last;
  logic [POS_W-1:0]  e_start;
  logic [POS_W-1:0]  e_end;
  logic [POS_W-1:0]  e_len;

  assign cap = (int'(cfg.field_limit) < MAX_FIELDS) ? FD_W'(cfg.field_limit)
                                                    : FD_W'(MAX_FIELDS);
  assign fd_inc   = {1'b0, fields_done_r} + 1'b1;
  assign pos_inc  = (pos_r == POS_LIMIT) ? POS_LIMIT : pos_r + 1'b1;
  assign is_quote = item.data_byte == cfs_pkg::QUOTE_CH;
  assign is_delim = item.data_byte == cfg.delimiter;
  assign is_blank = (item.data_byte == cfs_pkg::SPACE_CH) ||
                    (item.data_byte == cfs_pkg::TAB_CH);
  assign e_len    = e_end - e_start;
  assign emit_ok  = req && (fields_done_r < cap);
  assign emit_last = force_last || (fd_inc >= {1'b0, cap});

  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    fields_done_nxt = fields_done_r;
    cb_nxt          = cb_r;
    te_nxt          = te_r;
    text_seen_nxt   = text_seen_r;
    ovf_nxt         = ovf_r;
    eff_phase       = phase_r;
    eff_seen        = text_seen_r;
    req             = 1'b0;
    force_last      = 1'b0;
    e_start         = pos_r;
    e_end           = pos_r;

    if (step && item.func == cfs_pkg::FUNC_EOL) begin
      force_last = 1'b1;
      case (phase_r)
        PH_START:  req = 1'b1;
        PH_UNQ: begin
          req = 1'b1;
          if (text_seen_r) begin
            e_start = cb_r;
            e_end   = te_r;
          end
        end
        PH_QUOTED: begin
          req     = 1'b1;
          e_start = cb_r;
        end
        PH_QPEND: begin
          req     = 1'b1;
          e_start = cb_r;
          e_end   = te_r;
        end
        default: req = 1'b0;
      endcase
    end else if (step) begin
      ovf_nxt = ovf_r | (pos_r == POS_LIMIT);
      pos_nxt = pos_inc;
      if ((phase_r == PH_EMPTY || phase_r == PH_START) && is_quote) begin
        eff_phase = PH_DONE;
        phase_nxt = PH_QUOTED;
        cb_nxt    = pos_inc;
      end else if (phase_r == PH_EMPTY || phase_r == PH_START) begin
        eff_phase     = PH_UNQ;
        eff_seen      = 1'b0;
        phase_nxt     = PH_UNQ;
        text_seen_nxt = 1'b0;
      end
      case (eff_phase)
        PH_UNQ: begin
          if (is_delim) begin
            req = 1'b1;
            if (eff_seen) begin
              e_start = cb_r;
              e_end   = te_r;
            end
          end else if (!is_blank) begin
            if (!eff_seen) begin
              cb_nxt        = pos_r;
              text_seen_nxt = 1'b1;
            end
            te_nxt = pos_inc;
          end
        end
        PH_QUOTED: begin
          if (is_quote) begin
            phase_nxt = PH_QPEND;
            te_nxt    = pos_r;
          end
        end
        PH_QPEND: begin
          if (is_quote) begin
            phase_nxt = PH_QUOTED;
          end else begin
            req        = 1'b1;
            force_last = !is_delim;
            e_start    = cb_r;
            e_end      = te_r;
          end
        end
        default: req = 1'b0;
      endcase
      if (req && (fields_done_r < cap)) begin
        fields_done_nxt = fd_inc[FD_W-1:0];
        phase_nxt       = (force_last || (fd_inc >= {1'b0, cap})) ? PH_DONE : PH_START;
        text_seen_nxt   = 1'b0;
      end else if (req) begin
        phase_nxt = PH_DONE;
      end
    end

    if (step && item.func == cfs_pkg::FUNC_EOL) begin
      phase_nxt       = PH_EMPTY;
      pos_nxt         = '0;
      fields_done_nxt = '0;
      cb_nxt          = '0;
      te_nxt          = '0;
      text_seen_nxt   = 1'b0;
      ovf_nxt         = 1'b0;
    end
  end

  always_comb begin
    res_nxt               = res_r;
    res_valid_nxt         = res_valid_r;
    if (step) begin
      res_valid_nxt              = emit_ok;
      res_nxt.field_index        = cfs_pkg::IDX_W'(fields_done_r);
      res_nxt.start_ofs          = cfs_pkg::OFS_W'(e_start);
      res_nxt.field_length       = cfs_pkg::OFS_W'(e_len);
      res_nxt.last_field         = emit_last;
      res_nxt.line_overflow      = ovf_nxt & (item.func == cfs_pkg::FUNC_BYTE) |
                                   ovf_r & (item.func == cfs_pkg::FUNC_EOL);
    end else if (take) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      phase_r       <= PH_EMPTY;
      pos_r         <= '0;
      fields_done_r <= '0;
      cb_r          <= '0;
      te_r          <= '0;
      text_seen_r   <= 1'b0;
      ovf_r         <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      fields_done_r <= fields_done_nxt;
      cb_r          <= cb_nxt;
      te_r          <= te_nxt;
      text_seen_r   <= text_seen_nxt;
      ovf_r         <= ovf_nxt;
      res_valid_r   <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.func == cfs_pkg::FUNC_EOL |=>
      phase_r == PH_EMPTY && fields_done_r == '0 && pos_r == '0)
    else $error("line state not cleared after end of line");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit_ok && emit_last |=> phase_r == PH_DONE || phase_r == PH_EMPTY)
    else $error("parsing continues after last field");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_r == POS_LIMIT)
    else $error("overflow flagged without saturated offset");

  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EMPTY |-> pos_r == '0 && !ovf_r)
    else $error("empty line with nonzero offset");

endmodule

// ----- sv/csv_field_splitter_core.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// Splits one line of separated values into field offset and length beats.
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// in_if     in   func (byte or end of line), data_byte
// out_if    out  field_index, start_ofs, field_length, last_field, line_overflow
// cfg_if    in   index (0 delimiter, 1 field_limit), data
//
// one byte per cycle sustained while the result side is ready; a field beat leaves
// after its byte has passed the input register and then the result register
// synchronous active-low reset returns to an empty line, comma, 64 fields
// a stalled result holds; one more byte is taken into the input register
// register writes are always accepted, with cfg_if.ready tied high
// ----------------------------------------------------------------------------
module csv_field_splitter_core #(
  parameter int MAX_FIELDS = cfs_pkg::DEF_MAX_FIELDS,
  parameter int LINE_BYTES = cfs_pkg::DEF_LINE_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  cfs_in_if.sink    in_if,
  cfs_out_if.source out_if,
  cfs_cfg_if.sink   cfg_if
);

  logic             s1_valid_r;
  cfs_pkg::item_t   s1_item_r;
  cfs_pkg::cfg_t    cfg_r;
  logic             advance;
  logic             step;
  logic             res_valid;
  cfs_pkg::result_t res;

  assign advance     = !res_valid || out_if.ready;
  assign step        = s1_valid_r && advance;
  assign in_if.ready = !s1_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r.func      <= in_if.func;
      s1_item_r.data_byte <= in_if.data_byte;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cfg_r.delimiter   <= cfs_pkg::RST_DELIMITER;
      cfg_r.field_limit <= cfs_pkg::RST_FIELD_LIMIT;
    end else begin
      if (in_if.valid && in_if.ready) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.index == cfs_pkg::REG_DELIMITER) begin
        cfg_r.delimiter <= cfg_if.data;
      end
      if (cfg_if.valid && cfg_if.index == cfs_pkg::REG_FIELD_LIMIT) begin
        cfg_r.field_limit <= cfg_if.data[cfs_pkg::MAXF_W-1:0];
      end
    end
  end

  cfs_parser #(
    .MAX_FIELDS (MAX_FIELDS),
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .take      (out_if.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_if.valid         = res_valid;
  assign out_if.field_index   = res.field_index;
  assign out_if.start_ofs     = res.start_ofs;
  assign out_if.field_length  = res.field_length;
  assign out_if.last_field    = res.last_field;
  assign out_if.line_overflow = res.line_overflow;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives line bytes and end-of-line beats into csv_field_splitter_core under
// random valid/ready gaps and register settings. A line-state tracker in the
// bench works out each field beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int POS_CAP    = (cfs_pkg::DEF_LINE_BYTES < 65535) ?
                              cfs_pkg::DEF_LINE_BYTES : 65535;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_LEN   = 150;
  localparam int DRAIN_WAIT = 4;

  typedef enum logic [2:0] {
    LN_EMPTY, LN_START, LN_PLAIN, LN_QUOTED, LN_QCLOSE, LN_DONE
  } line_phase_t;

  typedef struct {
    logic             func;
    logic [7:0]       data;
    bit               typed;
    cfs_pkg::result_t res;
  } row_t;

  logic clk;
  logic rst_n;

  cfs_in_if  in_if ();
  cfs_out_if out_if ();
  cfs_cfg_if cfg_if ();

  csv_field_splitter_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // tracked line state and register copy
  logic [cfs_pkg::DATA_W-1:0] cur_delim;
  logic [cfs_pkg::MAXF_W-1:0] cur_maxf;
  line_phase_t       lphase;
  int unsigned       pos;
  int unsigned       nfields;
  int unsigned       fld_begin;
  bit                seen_text;
  int unsigned       text_stop;
  bit                ovf;

  cfs_pkg::result_t fields_due[$];
  cfs_pkg::item_t   line_q[$];

  int  errs;
  int  cycles;
  int  beats_in;
  int  fields_checked;
  int  settings;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  hold_req;
  int  hold_left;
  int  rx_gap;

  row_t dir_rows [27] = '{
    '{cfs_pkg::FUNC_EOL,  8'h00, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h61, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h2C, 1'b1, {6'd0, 16'd0, 16'd1, 1'b0, 1'b0}},
    '{cfs_pkg::FUNC_EOL,  8'h00, 1'b1, {6'd1, 16'd2, 16'd0, 1'b1, 1'b0}},
    '{cfs_pkg::FUNC_BYTE, 8'h20, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h09, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h2C, 1'b1, {6'd0, 16'd2, 16'd0, 1'b0, 1'b0}},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h71, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h7A, 1'b1, {6'd1, 16'd4, 16'd3, 1'b1, 1'b0}},
    '{cfs_pkg::FUNC_BYTE, 8'hFF, 1'b0, '0},
    '{cfs_pkg::FUNC_EOL,  8'hFF, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h00, 1'b0, '0},
    '{cfs_pkg::FUNC_EOL,  8'h00, 1'b1, {6'd0, 16'd1, 16'd1, 1'b1, 1'b0}},
    '{cfs_pkg::FUNC_BYTE, 8'h20, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h41, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h7E, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h09, 1'b0, '0},
    '{cfs_pkg::FUNC_EOL,  8'h00, 1'b1, {6'd0, 16'd1, 16'd2, 1'b1, 1'b0}},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h22, 1'b0, '0},
    '{cfs_pkg::FUNC_BYTE, 8'h2C, 1'b0, '0},
    '{cfs_pkg::FUNC_EOL,  8'h00, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned sat_inc(int unsigned p);
    return (p < POS_CAP) ? p + 1 : POS_CAP;
  endfunction

  function automatic void clear_line();
    lphase    = LN_EMPTY;
    pos       = 0;
    nfields   = 0;
    fld_begin = 0;
    seen_text = 1'b0;
    text_stop = 0;
    ovf       = 1'b0;
  endfunction

  function automatic bit issue_field(int unsigned start, int unsigned len, bit force_last,
                                     output cfs_pkg::result_t r);
    int unsigned cap;
    bit          last;
    cap = (cur_maxf < cfs_pkg::DEF_MAX_FIELDS) ? cur_maxf : cfs_pkg::DEF_MAX_FIELDS;
    r = '0;
    if (nfields >= cap) begin
      lphase = LN_DONE;
      return 1'b0;
    end
    last = force_last || (nfields + 1 >= cap);
    r.field_index   = nfields[cfs_pkg::IDX_W-1:0];
    r.start_ofs     = start[cfs_pkg::OFS_W-1:0];
    r.field_length  = len[cfs_pkg::OFS_W-1:0];
    r.last_field    = last;
    r.line_overflow = ovf;
    nfields++;
    lphase    = last ? LN_DONE : LN_START;
    seen_text = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit issue_plain(int unsigned p, bit force_last,
                                     output cfs_pkg::result_t r);
    if (seen_text) return issue_field(fld_begin, text_stop - fld_begin, force_last, r);
    return issue_field(p, 0, force_last, r);
  endfunction

  function automatic bit split_step(cfs_pkg::item_t it, output cfs_pkg::result_t r);
    int unsigned p;
    bit          hit;
    logic [7:0]  b;
    p   = pos;
    hit = 1'b0;
    b   = it.data_byte;
    r   = '0;
    if (it.func == cfs_pkg::FUNC_EOL) begin
      case (lphase)
        LN_START:  hit = issue_field(p, 0, 1'b1, r);
        LN_PLAIN:  hit = issue_plain(p, 1'b1, r);
        LN_QUOTED: hit = issue_field(fld_begin, p - fld_begin, 1'b1, r);
        LN_QCLOSE: hit = issue_field(fld_begin, text_stop - fld_begin, 1'b1, r);
        default: ;
      endcase
      clear_line();
      return hit;
    end
    if (p >= POS_CAP) begin
      p   = POS_CAP;
      ovf = 1'b1;
    end
    pos = sat_inc(p);
    if (lphase == LN_EMPTY || lphase == LN_START) begin
      if (b == cfs_pkg::QUOTE_CH) begin
        lphase    = LN_QUOTED;
        fld_begin = sat_inc(p);
        return 1'b0;
      end
      lphase    = LN_PLAIN;
      seen_text = 1'b0;
    end
    case (lphase)
      LN_PLAIN: begin
        if (b == cur_delim) begin
          hit = issue_plain(p, 1'b0, r);
        end else if (b != cfs_pkg::SPACE_CH && b != cfs_pkg::TAB_CH) begin
          if (!seen_text) begin
            fld_begin = p;
            seen_text = 1'b1;
          end
          text_stop = sat_inc(p);
        end
      end
      LN_QUOTED: begin
        if (b == cfs_pkg::QUOTE_CH) begin
          lphase    = LN_QCLOSE;
          text_stop = p;
        end
      end
      LN_QCLOSE: begin
        if (b == cfs_pkg::QUOTE_CH) lphase = LN_QUOTED;
        else if (b == cur_delim) hit = issue_field(fld_begin, text_stop - fld_begin, 1'b0, r);
        else hit = issue_field(fld_begin, text_stop - fld_begin, 1'b1, r);
        if (lphase == LN_QCLOSE) lphase = LN_DONE;
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic void cmp(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errs++;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    line_q.push_back(cfs_pkg::item_t'{cfs_pkg::FUNC_BYTE, b});
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 1) == 0) ? 8'h61 + 8'($urandom_range(0, 25))
                                      : 8'($urandom_range(0, 255));
    end while (b == cur_delim || b == cfs_pkg::QUOTE_CH);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 1) == 0) ? cfs_pkg::SPACE_CH : cfs_pkg::TAB_CH;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return cur_delim;
      1: return cfs_pkg::QUOTE_CH;
      2: return blank_byte();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_line();
    int nf;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 12)) push_byte(noise_byte());
      line_q.push_back(cfs_pkg::item_t'{cfs_pkg::FUNC_EOL, 8'($urandom_range(0, 255))});
      return;
    end
    nf = $urandom_range(1, 6);
    for (int k = 0; k < nf; k++) begin
      if (k > 0) push_byte(cur_delim);
      case ($urandom_range(0, 4))
        0: repeat ($urandom_range(0, 2)) push_byte(blank_byte());
        1, 2: begin
          repeat ($urandom_range(0, 2)) push_byte(blank_byte());
          repeat ($urandom_range(1, 5)) push_byte(text_byte());
          repeat ($urandom_range(0, 2)) push_byte(blank_byte());
        end
        3: begin
          push_byte(cfs_pkg::QUOTE_CH);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              push_byte(cfs_pkg::QUOTE_CH);
              push_byte(cfs_pkg::QUOTE_CH);
            end else begin
              push_byte(text_byte());
            end
          end
          push_byte(cfs_pkg::QUOTE_CH);
          if ($urandom_range(0, 5) == 0) push_byte(text_byte());
        end
        default: begin
          push_byte(cfs_pkg::QUOTE_CH);
          repeat ($urandom_range(0, 3)) push_byte(text_byte());
        end
      endcase
    end
    if ($urandom_range(0, 5) == 0) push_byte(cur_delim);
    line_q.push_back(cfs_pkg::item_t'{cfs_pkg::FUNC_EOL, 8'($urandom_range(0, 255))});
  endfunction

  // leaves valid high; the next negedge belongs to the caller
  task automatic send_beat(cfs_pkg::item_t it, bit typed, cfs_pkg::result_t want);
    cfs_pkg::result_t r;
    bit               hit;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 13)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.func      <= it.func;
    in_if.data_byte <= it.data_byte;
    do @(posedge clk); while (!in_if.ready);
    beats_in++;
    hit = split_step(it, r);
    if (typed) fields_due.push_back(want);
    else if (hit) fields_due.push_back(r);
  endtask

  task automatic send_line_q();
    while (line_q.size() != 0) send_beat(line_q.pop_front(), 1'b0, '0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] d, logic [6:0] m);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= cfs_pkg::REG_DELIMITER;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cur_delim = d;
    @(negedge clk);
    cfg_if.index <= cfs_pkg::REG_FIELD_LIMIT;
    cfg_if.data  <= {1'b0, m};
    do @(posedge clk); while (!cfg_if.ready);
    cur_maxf = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // result side: bursts of stall plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cfs_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (fields_due.size() == 0) begin
        $error("field beat with nothing expected");
        errs++;
      end else begin
        want = fields_due.pop_front();
        cmp("field_index", want.field_index, out_if.field_index);
        cmp("start_ofs", want.start_ofs, out_if.start_ofs);
        cmp("field_length", want.field_length, out_if.field_length);
        cmp("last_field", want.last_field, out_if.last_field);
        cmp("line_overflow", want.line_overflow, out_if.line_overflow);
        fields_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [7:0] d;
    logic [6:0] m;
    int         goal;
    errs           = 0;
    cycles         = 0;
    beats_in       = 0;
    fields_checked = 0;
    settings       = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    rx_gap         = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rst_n          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.func      = cfs_pkg::FUNC_BYTE;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = cfs_pkg::REG_DELIMITER;
    cfg_if.data     = '0;
    cur_delim = cfs_pkg::RST_DELIMITER;
    cur_maxf  = cfs_pkg::RST_FIELD_LIMIT;
    clear_line();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(cfs_pkg::item_t'{dir_rows[i].func, dir_rows[i].data}, dir_rows[i].typed,
                dir_rows[i].res);

    // full field cap while the result side is held off
    settle();
    set_config(cfs_pkg::RST_DELIMITER, 7'd64);
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (70) push_byte(cfs_pkg::RST_DELIMITER);
    line_q.push_back(cfs_pkg::item_t'{cfs_pkg::FUNC_EOL, 8'h00});
    send_line_q();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin d = cfs_pkg::TAB_CH; m = 7'd64; end
        1: begin d = 8'h00; m = 7'd1; end
        2: begin d = 8'hFF; m = 7'($urandom_range(2, 8)); end
        3: begin d = cfs_pkg::QUOTE_CH; m = 7'd3; end
        4: begin d = cfs_pkg::SPACE_CH; m = 7'd64; end
        default: begin d = 8'($urandom_range(0, 255)); m = 7'($urandom_range(1, 64)); end
      endcase
      settle();
      set_config(d, m);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      goal = beats_in + 80;
      while (beats_in < goal) begin
        build_line();
        send_line_q();
      end
    end

    settle();
    set_config(cfs_pkg::RST_DELIMITER, 7'($urandom_range(1, 64)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    goal = beats_in + 80;
    while (beats_in < goal) begin
      build_line();
      send_line_q();
    end

    settle();
    $display("summary: %0d input beats, %0d field beats checked, %0d register settings",
             beats_in, fields_checked, settings);
    $display("summary: directed rows, field cap under a held result side, random lines");
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
